// ----- design/bta_pkg.sv -----
// Shared types, constants and helpers for the bakery ticket arbiter.
package bta_pkg;

    localparam int THREADS     = 8;
    localparam int TICKET_BITS = 16;

    localparam int IDX_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int ACT_W   = $clog2(THREADS + 1);
    localparam int TID_W   = 3;
    localparam int ISSUE_W = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 4;
    localparam int ADDR_W  = 3;

    localparam logic [TICKET_BITS-1:0] TICKET_MAX = {TICKET_BITS{1'b1}};
    localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'((THREADS < 8) ? THREADS : 8);
    localparam logic [ADDR_W-1:0] ADDR_ACTIVE = '0;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_RANGE    = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ACQUIRE = 1'b0,
        REQ_RELEASE = 1'b1
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // Running record carried down the cell chain during a scan.
    typedef struct packed {
        logic [TICKET_BITS-1:0] max_tkt;
        logic                   all_found;
        logic [TICKET_BITS-1:0] all_tkt;
        logic [IDX_W-1:0]       all_idx;
        logic                   exc_found;
        logic [TICKET_BITS-1:0] exc_tkt;
        logic [IDX_W-1:0]       exc_idx;
    } scan_rec_t;

    // Ticket write broadcast to all cells at the end of a scan.
    typedef struct packed {
        logic                   en;
        logic [IDX_W-1:0]       idx;
        logic [TICKET_BITS-1:0] value;
    } tkt_wr_t;

    // Written active count: zero acts as one, above THREADS acts as THREADS.
    function automatic logic [ACT_W-1:0] clamp_active(input logic [CFG_W-1:0] v);
        logic [ACT_W-1:0] r;
        if (v == '0) begin
            r = ACT_W'(1);
        end else if (32'(v) > THREADS) begin
            r = ACT_W'(THREADS);
        end else begin
            r = ACT_W'(v);
        end
        return r;
    endfunction

endpackage

// ----- design/bta_cell.sv -----
// One arbiter cell: holds one thread's ticket and folds it into the passing scan record.
module bta_cell
    import bta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic             cell_active,
    input  logic [IDX_W-1:0] req_tid,
    input  tkt_wr_t          wr,
    input  scan_rec_t        rec_in,
    input  logic             vld_in,
    output scan_rec_t        rec_out,
    output logic             vld_out
);

    logic [TICKET_BITS-1:0] ticket_reg;
    scan_rec_t              rec_reg;
    scan_rec_t              rec_next;
    logic                   vld_reg;

    always_comb
    begin
        rec_next = rec_in;
        if (cell_active)
        begin
            if (ticket_reg > rec_in.max_tkt)
            begin
                rec_next.max_tkt = ticket_reg;
            end
            // Strict compare keeps the lower thread number on equal tickets.
            if (ticket_reg != '0 && (!rec_in.all_found || ticket_reg < rec_in.all_tkt))
            begin
                rec_next.all_found = 1'b1;
                rec_next.all_tkt   = ticket_reg;
                rec_next.all_idx   = cell_idx;
            end
            if (ticket_reg != '0 && cell_idx != req_tid &&
                (!rec_in.exc_found || ticket_reg < rec_in.exc_tkt))
            begin
                rec_next.exc_found = 1'b1;
                rec_next.exc_tkt   = ticket_reg;
                rec_next.exc_idx   = cell_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticket_reg <= '0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_in;
            if (wr.en && wr.idx == cell_idx)
            begin
                ticket_reg <= wr.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (vld_in)
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec_out = rec_reg;
    assign vld_out = vld_reg;

endmodule

// ----- design/bakery_ticket_arbiter_core.sv -----
// Top level of the bakery ticket arbiter: request control, cell chain and register port.
//
// The arbiter keeps one ticket per thread in a chain of THREADS cells. A request is
// accepted when start is high and busy is low; busy then stays high until the result
// is shown. Each request launches one scan record that walks the cell chain, one cell
// per clock, collecting the largest active ticket and the lowest holder both with and
// without the requesting thread. A request passes through the launch register, each
// cell register in turn and the result register before its result is shown. busy
// drops in the same cycle as the result strobe rises, so the next request can be
// accepted at the edge that ends the strobe cycle; a new request is not taken until
// the scan of the last one has ended. The scan length through the cell chain sets
// the request rate. Every result is on the result ports for exactly one cycle,
// marked by result_valid, and the receiver cannot stall it: a transfer completes at
// the clock edge that ends that cycle. The active thread count is written through
// the APB port at byte address 0 and should only be changed while the block is idle;
// only the low four bits of the written value are used, a written zero acts as one
// and values above the thread count are capped.
module bakery_ticket_arbiter_core
    import bta_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Request channel.
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [TID_W-1:0]    thread_id,
    // Result channel.
    output logic                result_valid,
    output logic [ISSUE_W-1:0]  ticket_issued,
    output logic                grant_valid,
    output logic [TID_W-1:0]    granted_thread,
    output logic [STAT_W-1:0]   status,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Control state.
    state_t           state_reg, state_next;
    logic             launch_reg, launch_next;
    logic             done_reg, done_next;
    logic [ACT_W-1:0] active_reg;

    // Request held for the length of the scan.
    req_t             req_reg;
    logic [IDX_W-1:0] tid_reg;
    logic             in_range_reg;

    // Registered result.
    logic [ISSUE_W-1:0] issued_reg, issued_next;
    logic               gvalid_reg, gvalid_next;
    logic [TID_W-1:0]   gthread_reg, gthread_next;
    status_t            status_reg, status_next;

    // Cell chain.
    scan_rec_t        rec [0:THREADS];
    logic             vld [0:THREADS];
    logic [THREADS:0] vld_vec;
    tkt_wr_t          wr;
    scan_rec_t        fin;

    logic accept;
    logic cfg_write;

    assign accept    = start && !busy;
    assign busy      = (state_reg == ST_SCAN);
    assign cfg_write = psel && penable && pwrite && pready;

    // The scan record enters the first cell in the cycle after acceptance, once the
    // requesting thread number has been captured.
    assign rec[0] = '0;
    assign vld[0] = launch_reg;

    for (genvar i = 0; i < THREADS; i++)
    begin : g_cell
        bta_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_idx    (IDX_W'(i)),
            .cell_active (ACT_W'(i) < active_reg),
            .req_tid     (tid_reg),
            .wr          (wr),
            .rec_in      (rec[i]),
            .vld_in      (vld[i]),
            .rec_out     (rec[i+1]),
            .vld_out     (vld[i+1])
        );
    end

    for (genvar i = 0; i <= THREADS; i++)
    begin : g_vld
        assign vld_vec[i] = vld[i];
    end

    assign fin = rec[THREADS];

    // Next state, result and the ticket write that ends a request. A new ticket is
    // always above every other active ticket, so it wins the grant only when no other
    // thread holds one; that is why the record keeps a holder with the requester left
    // out as well as the holder over all threads.
    always_comb
    begin
        state_next   = state_reg;
        launch_next  = 1'b0;
        done_next    = 1'b0;
        issued_next  = issued_reg;
        gvalid_next  = gvalid_reg;
        gthread_next = gthread_reg;
        status_next  = status_reg;
        wr           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_SCAN;
                    launch_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (vld[THREADS])
                begin
                    state_next  = ST_IDLE;
                    done_next   = 1'b1;
                    issued_next = '0;
                    status_next = STAT_OK;
                    gvalid_next = fin.all_found;
                    gthread_next = fin.all_found ? TID_W'(fin.all_idx) : '0;
                    if (!in_range_reg)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else if (req_reg == REQ_ACQUIRE)
                    begin
                        if (fin.max_tkt == TICKET_MAX)
                        begin
                            status_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            wr.en        = 1'b1;
                            wr.idx       = tid_reg;
                            wr.value     = fin.max_tkt + 1'b1;
                            issued_next  = ISSUE_W'(fin.max_tkt + 1'b1);
                            gvalid_next  = 1'b1;
                            gthread_next = fin.exc_found ? TID_W'(fin.exc_idx)
                                                         : TID_W'(tid_reg);
                        end
                    end
                    else
                    begin
                        wr.en        = 1'b1;
                        wr.idx       = tid_reg;
                        wr.value     = '0;
                        gvalid_next  = fin.exc_found;
                        gthread_next = fin.exc_found ? TID_W'(fin.exc_idx) : '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
            done_reg   <= 1'b0;
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            done_reg   <= done_next;
            if (cfg_write && paddr == ADDR_ACTIVE)
            begin
                active_reg <= clamp_active(pwdata[CFG_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg      <= req_t'(req_type);
            tid_reg      <= IDX_W'(thread_id);
            in_range_reg <= (8'(thread_id) < 8'(active_reg));
        end
        issued_reg  <= issued_next;
        gvalid_reg  <= gvalid_next;
        gthread_reg <= gthread_next;
        status_reg  <= status_next;
    end

    assign result_valid   = done_reg;
    assign ticket_issued  = issued_reg;
    assign grant_valid    = gvalid_reg;
    assign granted_thread = gthread_reg;
    assign status         = status_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ACTIVE) ? 32'(active_reg) : '0;

    // Only one scan record is ever in flight.
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(vld_vec))
        else $error("more than one scan record in the cell chain");

    // A scan record only exists while a request is being served.
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        vld[THREADS] |-> busy)
        else $error("scan record reached the chain end while idle");

    // A result transfer ends a request, so the block is idle when it is shown.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && $past(busy))
        else $error("result shown outside the end of a request");

    // A freshly issued ticket means somebody holds the lock.
    a_issue_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ticket_issued != '0) |-> grant_valid)
        else $error("ticket issued without a grant");

endmodule
